FILE: design/hkt_pkg.sv
// Shared types, constants and helpers for the held key tracker.
package hkt_pkg;

    // Default sizes.
    localparam int DEF_HELD_SLOTS     = 16;
    localparam int DEF_SCANCODE_COUNT = 512;

    // Field widths.
    localparam int PHYS_W  = 9;
    localparam int KEY_W   = 16;
    localparam int FLAGS_W = 8;
    localparam int MASK_W  = 4;

    // Operation codes.
    localparam logic [1:0] OP_KEY      = 2'd0;
    localparam logic [1:0] OP_CONSUME  = 2'd1;
    localparam logic [1:0] OP_RELALL   = 2'd2;
    localparam logic [1:0] OP_LINKFAIL = 2'd3;

    // Low bytes of modifier key codes.
    localparam logic [7:0] KC_LSHIFT = 8'hA0;
    localparam logic [7:0] KC_RSHIFT = 8'hA1;
    localparam logic [7:0] KC_LCTRL  = 8'hA2;
    localparam logic [7:0] KC_RCTRL  = 8'hA3;
    localparam logic [7:0] KC_LALT   = 8'hA4;
    localparam logic [7:0] KC_RALT   = 8'hA5;
    localparam logic [7:0] KC_LMETA  = 8'h5B;
    localparam logic [7:0] KC_RMETA  = 8'h5C;

    // Modifier mask bits.
    localparam logic [MASK_W-1:0] MOD_SHIFT = 4'b0001;
    localparam logic [MASK_W-1:0] MOD_CTRL  = 4'b0010;
    localparam logic [MASK_W-1:0] MOD_ALT   = 4'b0100;
    localparam logic [MASK_W-1:0] MOD_META  = 4'b1000;
    localparam logic [MASK_W-1:0] MOD_NONE  = 4'b0000;

    // Input word.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [PHYS_W-1:0]  physical_code;
        logic [KEY_W-1:0]   key_code;
        logic [FLAGS_W-1:0] key_flags;
        logic               is_down;
        logic               is_repeat;
        logic               allow_press;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [KEY_W-1:0]   out_key_code;
        logic               pressed;
        logic [MASK_W-1:0]  modifier_mask;
        logic [FLAGS_W-1:0] out_flags;
        logic               last;
    } t_out_word;

    // One entry of the held key table.
    typedef struct packed {
        logic [PHYS_W-1:0]  phys;
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] flags;
    } t_entry;

    // Update commands for the held key table.
    typedef struct packed {
        logic append;
        logic remove;
    } t_tbl_cmd;

    // Modifier bits contributed by one held key code.
    function automatic logic [MASK_W-1:0] mod_bits(input logic [7:0] low_byte);
        logic [MASK_W-1:0] m;
        case (low_byte)
            KC_LSHIFT, KC_RSHIFT: m = MOD_SHIFT;
            KC_LCTRL,  KC_RCTRL:  m = MOD_CTRL;
            KC_LALT,   KC_RALT:   m = MOD_ALT;
            KC_LMETA,  KC_RMETA:  m = MOD_META;
            default:              m = MOD_NONE;
        endcase
        return m;
    endfunction

endpackage

FILE: design/held_key_tracker.sv
// Held key tracker top level: sequencer around the table, compare unit and bitmap.
//
// Input channel i_in_valid/o_in_ready carries one key event or command word;
// output channel o_out_valid/i_out_ready carries press and release packets.
// Every packet carries the modifier mask of the held table after its update,
// and the last packet caused by one input word has the last bit set.
// After reset the suppressed bitmap is cleared one scancode per cycle, and the
// input stays not ready until all SCANCODE_COUNT bits (512 by default) are clear.
// One word is worked on at a time. A single compare unit walks the held table
// one entry per cycle, across the N held keys for a key event, and again in
// an alias scan when a held key is released. Release all repeats a remove and
// alias scan for each held key, newest first. Repeats and link failure words
// are taken in the idle state and start no scan.
// Results sit in an output register; a stalled receiver holds the sequencer
// in its emit step until the register is free, and no packet is lost.
// After a link failure word, no packet is sent until reset; key words are then
// ignored, but consume and release all words still update the table and bitmap.
module held_key_tracker #(
    parameter int HELD_SLOTS     = hkt_pkg::DEF_HELD_SLOTS,
    parameter int SCANCODE_COUNT = hkt_pkg::DEF_SCANCODE_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hkt_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hkt_pkg::t_out_word  o_out_data
);

    localparam int CW = $clog2(HELD_SLOTS + 1);
    localparam int IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_RALL   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    // What the current table scan is looking for.
    typedef enum logic [2:0] {
        M_PRESS = 3'b001,
        M_FIND  = 3'b010,
        M_ALIAS = 3'b100
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [CW-1:0]                   r_idx;
    logic [IW-1:0]                   r_at;
    logic                            r_found;
    logic                            r_alias;
    logic                            r_rall;
    logic                            r_allow;
    logic                            r_emit_press;
    logic                            r_link_failed;
    logic [hkt_pkg::PHYS_W-1:0]      r_p;
    logic [hkt_pkg::KEY_W-1:0]       r_qkey;
    logic [hkt_pkg::FLAGS_W-1:0]     r_qflags;
    logic                            r_out_valid;
    hkt_pkg::t_out_word              r_out;

    logic                            in_fire;
    logic                            out_load;
    logic                            scan_done;
    logic                            emit_next_rall;
    logic [IW-1:0]                   newest;

    hkt_pkg::t_tbl_cmd               tbl_cmd;
    logic [IW-1:0]                   tbl_at;
    logic [IW-1:0]                   tbl_rd_idx;
    hkt_pkg::t_entry                 tbl_new;
    hkt_pkg::t_entry                 tbl_rd;
    logic [CW-1:0]                   tbl_count;
    logic [hkt_pkg::MASK_W-1:0]      tbl_mask;

    logic                            phys_hit;
    logic                            alias_hit;

    logic                            sup_wr_en;
    logic [hkt_pkg::PHYS_W-1:0]      sup_wr_addr;
    logic                            sup_wr_bit;
    logic                            sup_rd_bit;
    logic                            sup_clearing;

    hkt_table #(
        .HELD_SLOTS (HELD_SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (tbl_cmd),
        .i_at     (tbl_at),
        .i_new    (tbl_new),
        .i_rd_idx (tbl_rd_idx),
        .o_rd     (tbl_rd),
        .o_count  (tbl_count),
        .o_mask   (tbl_mask)
    );

    hkt_cmp u_cmp (
        .i_entry     (tbl_rd),
        .i_phys      (r_p),
        .i_key       (r_qkey),
        .i_flags     (r_qflags),
        .o_phys_hit  (phys_hit),
        .o_alias_hit (alias_hit)
    );

    hkt_supmap #(
        .SCANCODE_COUNT (SCANCODE_COUNT)
    ) u_supmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (sup_wr_en),
        .i_wr_addr  (sup_wr_addr),
        .i_wr_bit   (sup_wr_bit),
        .i_rd_en    (in_fire),
        .i_rd_addr  (i_in_data.physical_code),
        .o_rd_bit   (sup_rd_bit),
        .o_clearing (sup_clearing)
    );

    // Handshakes.
    assign o_in_ready = (r_state == S_IDLE) && !sup_clearing;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_EMIT) && !r_link_failed
                        && (!r_out_valid || i_out_ready);

    assign scan_done      = (r_idx >= tbl_count);
    assign newest         = IW'(tbl_count - CW'(1));
    assign emit_next_rall = r_rall && (tbl_count != '0);

    // Table access for the current step.
    always_comb begin
        tbl_cmd    = '0;
        tbl_at     = r_at;
        tbl_rd_idx = r_idx[IW-1:0];
        tbl_new    = '{phys: r_p, key: r_qkey, flags: r_qflags};
        case (r_state)
            S_RALL: begin
                tbl_rd_idx     = newest;
                tbl_at         = newest;
                tbl_cmd.remove = 1'b1;
            end
            S_DECIDE: begin
                if (r_mode == M_PRESS) begin
                    tbl_cmd.append = !sup_rd_bit && !r_found && r_allow
                                     && (tbl_count < CW'(HELD_SLOTS));
                end else if (r_mode == M_FIND) begin
                    tbl_cmd.remove = r_found;
                end
            end
            default: begin
            end
        endcase
    end

    // Suppressed bitmap writes.
    always_comb begin
        sup_wr_en   = 1'b0;
        sup_wr_addr = i_in_data.physical_code;
        sup_wr_bit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.opcode == hkt_pkg::OP_CONSUME) begin
                        sup_wr_en  = 1'b1;
                        sup_wr_bit = 1'b1;
                    end else if (i_in_data.opcode == hkt_pkg::OP_KEY
                                 && !i_in_data.is_down
                                 && i_in_data.physical_code != '0
                                 && !r_link_failed) begin
                        sup_wr_en  = 1'b1;
                        sup_wr_bit = 1'b0;
                    end
                end
            end
            S_RALL: begin
                sup_wr_en   = 1'b1;
                sup_wr_addr = tbl_rd.phys;
                sup_wr_bit  = 1'b1;
            end
            S_DECIDE: begin
                sup_wr_addr = r_p;
                sup_wr_bit  = 1'b1;
                sup_wr_en   = (r_mode == M_PRESS) && !sup_rd_bit && !r_found && !r_allow;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.opcode)
                        hkt_pkg::OP_KEY: begin
                            if (i_in_data.physical_code != '0 && !r_link_failed
                                && (!i_in_data.is_down || !i_in_data.is_repeat)) begin
                                n_state = S_SCAN;
                            end
                        end
                        hkt_pkg::OP_CONSUME: n_state = S_SCAN;
                        hkt_pkg::OP_RELALL: begin
                            if (tbl_count != '0) begin
                                n_state = S_RALL;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_RALL: n_state = S_SCAN;
            S_DECIDE: begin
                case (r_mode)
                    M_PRESS: begin
                        n_state = tbl_cmd.append && !r_alias ? S_EMIT : S_IDLE;
                    end
                    M_FIND: n_state = r_found ? S_SCAN : S_IDLE;
                    M_ALIAS: begin
                        if (!r_alias) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = emit_next_rall ? S_RALL : S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (r_link_failed || out_load) begin
                    n_state = emit_next_rall ? S_RALL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_link_failed <= 1'b0;
            r_rall        <= 1'b0;
            r_mode        <= M_PRESS;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_rall <= (i_in_data.opcode == hkt_pkg::OP_RELALL);
                r_mode <= (i_in_data.opcode == hkt_pkg::OP_KEY && i_in_data.is_down)
                          ? M_PRESS : M_FIND;
                if (i_in_data.opcode == hkt_pkg::OP_LINKFAIL) begin
                    r_link_failed <= 1'b1;
                end
            end else if (r_state == S_RALL
                         || (r_state == S_DECIDE && r_mode == M_FIND)) begin
                r_mode <= M_ALIAS;
            end
        end
    end

    // Word and scan registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p          <= i_in_data.physical_code;
            r_qkey       <= i_in_data.key_code;
            r_qflags     <= i_in_data.key_flags;
            r_allow      <= i_in_data.allow_press;
            r_emit_press <= (i_in_data.opcode == hkt_pkg::OP_KEY) && i_in_data.is_down;
        end
        if (in_fire || r_state == S_RALL || r_state == S_DECIDE) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_alias <= 1'b0;
        end else if (r_state == S_SCAN && !scan_done) begin
            r_idx <= r_idx + CW'(1);
            if (phys_hit && r_mode != M_ALIAS) begin
                r_found <= 1'b1;
                r_at    <= r_idx[IW-1:0];
                if (r_mode == M_FIND) begin
                    r_qkey   <= tbl_rd.key;
                    r_qflags <= tbl_rd.flags;
                end
            end
            if (alias_hit && r_mode != M_FIND) begin
                r_alias <= 1'b1;
            end
        end
        if (r_state == S_RALL) begin
            r_emit_press <= 1'b0;
            r_qkey       <= tbl_rd.key;
            r_qflags     <= tbl_rd.flags;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_key_code  <= r_qkey;
            r_out.pressed       <= r_emit_press;
            r_out.modifier_mask <= tbl_mask;
            r_out.out_flags     <= r_qflags;
            r_out.last          <= !emit_next_rall;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_count <= CW'(HELD_SLOTS))
        else $error("held table count above its size");

    // A link failure word latches the failure flag.
    a_link_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.opcode == hkt_pkg::OP_LINKFAIL) |=> r_link_failed)
        else $error("link failure not latched");

    // No packet is loaded once the link has failed.
    a_no_send_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_link_failed)
        else $error("packet sent after link failure");

    // No word is taken while the bitmap is still being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !sup_clearing)
        else $error("word accepted during clearing pass");

    // Removal always shrinks the table by one entry.
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_cmd.remove |=> (tbl_count == $past(tbl_count) - CW'(1)))
        else $error("removal did not shrink table");
`endif

endmodule

FILE: design/hkt_cmp.sv
// Shared compare unit: matches one table entry against the current query.
module hkt_cmp (
    input  hkt_pkg::t_entry                 i_entry,
    input  logic [hkt_pkg::PHYS_W-1:0]      i_phys,
    input  logic [hkt_pkg::KEY_W-1:0]       i_key,
    input  logic [hkt_pkg::FLAGS_W-1:0]     i_flags,
    output logic                            o_phys_hit,
    output logic                            o_alias_hit
);

    // Physical match finds the held key; code and flags match finds an alias.
    assign o_phys_hit  = (i_entry.phys == i_phys);
    assign o_alias_hit = (i_entry.key == i_key) && (i_entry.flags == i_flags);

endmodule

FILE: design/hkt_table.sv
// Ordered table of held keys with append, ordered removal and modifier mask.
module hkt_table #(
    parameter int HELD_SLOTS = hkt_pkg::DEF_HELD_SLOTS,
    parameter int CW = $clog2(HELD_SLOTS + 1),
    parameter int IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hkt_pkg::t_tbl_cmd             i_cmd,
    input  logic [IW-1:0]                 i_at,
    input  hkt_pkg::t_entry               i_new,
    input  logic [IW-1:0]                 i_rd_idx,
    output hkt_pkg::t_entry               o_rd,
    output logic [CW-1:0]                 o_count,
    output logic [hkt_pkg::MASK_W-1:0]    o_mask
);

    hkt_pkg::t_entry r_ent [HELD_SLOTS];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    // Entry storage: later entries move up on removal, new keys go at the end.
    for (genvar g = 0; g < HELD_SLOTS; g++) begin : g_slot
        if (g < HELD_SLOTS - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_cmd.remove && (IW'(g) >= i_at) && (CW'(g + 1) < r_count)) begin
                    r_ent[g] <= r_ent[g + 1];
                end else if (i_cmd.append && (r_count == CW'(g))) begin
                    r_ent[g] <= i_new;
                end
            end
        end else begin : g_end
            always_ff @(posedge i_clk) begin
                if (i_cmd.append && (r_count == CW'(g))) begin
                    r_ent[g] <= i_new;
                end
            end
        end
    end

    // Fill count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Modifier mask over all held entries.
    always_comb begin
        o_mask = hkt_pkg::MOD_NONE;
        for (int i = 0; i < HELD_SLOTS; i++) begin
            if (CW'(i) < r_count) begin
                o_mask = o_mask | hkt_pkg::mod_bits(r_ent[i].key[7:0]);
            end
        end
    end

    assign o_rd    = r_ent[i_rd_idx];
    assign o_count = r_count;

endmodule

FILE: design/hkt_supmap.sv
// Suppressed key bitmap: one bit per scancode, cleared by a pass after reset.
module hkt_supmap #(
    parameter int SCANCODE_COUNT = hkt_pkg::DEF_SCANCODE_COUNT,
    parameter int AW = $clog2(SCANCODE_COUNT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [hkt_pkg::PHYS_W-1:0]    i_wr_addr,
    input  logic                          i_wr_bit,
    input  logic                          i_rd_en,
    input  logic [hkt_pkg::PHYS_W-1:0]    i_rd_addr,
    output logic                          o_rd_bit,
    output logic                          o_clearing
);

    logic          r_mem [SCANCODE_COUNT];
    logic [AW-1:0] r_clr_idx;
    logic          r_clearing;
    logic          r_rd_bit;
    logic          wr_in_range;
    logic          rd_in_range;

    // Codes past the end of the map read as zero and ignore writes.
    assign wr_in_range = (32'(i_wr_addr) < SCANCODE_COUNT);
    assign rd_in_range = (32'(i_rd_addr) < SCANCODE_COUNT);

    // Clearing pass control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(SCANCODE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Write port.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= 1'b0;
        end else if (i_wr_en && wr_in_range) begin
            r_mem[AW'(i_wr_addr)] <= i_wr_bit;
        end
    end

    // Registered read port; the value holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bit <= rd_in_range ? r_mem[AW'(i_rd_addr)] : 1'b0;
        end
    end

    assign o_rd_bit   = r_rd_bit;
    assign o_clearing = r_clearing;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the held key tracker: directed words, random key sessions, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = hkt_pkg::DEF_HELD_SLOTS;
    localparam int CODES        = hkt_pkg::DEF_SCANCODE_COUNT;
    localparam int POOL_SIZE    = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // One directed word, with a typed packet where the answer is obvious.
    typedef struct packed {
        hkt_pkg::t_in_word  w;
        logic               typed;
        hkt_pkg::t_out_word want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    hkt_pkg::t_in_word  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    hkt_pkg::t_out_word o_out_data;

    // Predicted state of the held table, the suppressed bitmap and the link.
    logic [hkt_pkg::PHYS_W-1:0]  held_phys_tbl  [SLOTS];
    logic [hkt_pkg::KEY_W-1:0]   held_key_tbl   [SLOTS];
    logic [hkt_pkg::FLAGS_W-1:0] held_flags_tbl [SLOTS];
    int                          held_total = 0;
    bit                          suppressed [CODES];
    bit                          link_down = 1'b0;

    // Packets caused by the word being predicted, and packets still owed.
    hkt_pkg::t_out_word burst[$];
    hkt_pkg::t_out_word pending_packets[$];

    // Key session: a pool of physical keys with fixed codes and flags.
    logic [hkt_pkg::PHYS_W-1:0]  pool_phys  [POOL_SIZE];
    logic [hkt_pkg::KEY_W-1:0]   pool_key   [POOL_SIZE];
    logic [hkt_pkg::FLAGS_W-1:0] pool_flags [POOL_SIZE];

    t_row rows[$];
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   holds_asked   = 0;
    int   holds_done    = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;

    held_key_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Modifier mask of everything currently held.
    function automatic logic [hkt_pkg::MASK_W-1:0] held_modifiers();
        logic [hkt_pkg::MASK_W-1:0] m;
        m = hkt_pkg::MOD_NONE;
        for (int i = 0; i < held_total; i++) begin
            case (held_key_tbl[i][7:0])
                hkt_pkg::KC_LSHIFT, hkt_pkg::KC_RSHIFT: m |= hkt_pkg::MOD_SHIFT;
                hkt_pkg::KC_LCTRL, hkt_pkg::KC_RCTRL:   m |= hkt_pkg::MOD_CTRL;
                hkt_pkg::KC_LALT, hkt_pkg::KC_RALT:     m |= hkt_pkg::MOD_ALT;
                hkt_pkg::KC_LMETA, hkt_pkg::KC_RMETA:   m |= hkt_pkg::MOD_META;
                default:                                m |= hkt_pkg::MOD_NONE;
            endcase
        end
        return m;
    endfunction

    function automatic int held_slot(input logic [hkt_pkg::PHYS_W-1:0] p);
        for (int i = 0; i < held_total; i++) begin
            if (held_phys_tbl[i] == p) return i;
        end
        return -1;
    endfunction

    function automatic bit alias_held(input logic [hkt_pkg::KEY_W-1:0] k,
                                      input logic [hkt_pkg::FLAGS_W-1:0] f);
        for (int i = 0; i < held_total; i++) begin
            if (held_key_tbl[i] == k && held_flags_tbl[i] == f) return 1'b1;
        end
        return 1'b0;
    endfunction

    // A packet is built against the table as it stands after the update.
    task automatic queue_packet(input logic [hkt_pkg::KEY_W-1:0] k, input bit down,
                                input logic [hkt_pkg::FLAGS_W-1:0] f);
        hkt_pkg::t_out_word pkt;
        if (!link_down) begin
            pkt.out_key_code  = k;
            pkt.pressed       = down;
            pkt.modifier_mask = held_modifiers();
            pkt.out_flags     = f;
            pkt.last          = 1'b0;
            burst = {burst, pkt};
        end
    endtask

    // Remove a held key, keeping order, and report it unless an alias remains.
    task automatic drop_key(input logic [hkt_pkg::PHYS_W-1:0] p);
        int                          at;
        logic [hkt_pkg::KEY_W-1:0]   k;
        logic [hkt_pkg::FLAGS_W-1:0] f;
        at = held_slot(p);
        if (at < 0) return;
        k = held_key_tbl[at];
        f = held_flags_tbl[at];
        for (int i = at; i + 1 < held_total; i++) begin
            held_phys_tbl[i]  = held_phys_tbl[i + 1];
            held_key_tbl[i]   = held_key_tbl[i + 1];
            held_flags_tbl[i] = held_flags_tbl[i + 1];
        end
        held_total--;
        if (!alias_held(k, f)) queue_packet(k, 1'b0, f);
    endtask

    // Work out the packets one accepted word causes and update the state.
    task automatic track_word(input hkt_pkg::t_in_word w);
        logic [hkt_pkg::PHYS_W-1:0] q;
        bit                         al;
        hkt_pkg::t_out_word         tail;
        burst.delete();
        case (w.opcode)
            hkt_pkg::OP_KEY: begin
                if (w.physical_code != '0 && !link_down) begin
                    if (!w.is_down) begin
                        suppressed[w.physical_code] = 1'b0;
                        drop_key(w.physical_code);
                    end else if (w.is_repeat || suppressed[w.physical_code] ||
                                 held_slot(w.physical_code) >= 0) begin
                        // Repeats, suppressed keys and keys already held are dropped.
                    end else if (!w.allow_press) begin
                        suppressed[w.physical_code] = 1'b1;
                    end else if (held_total < SLOTS) begin
                        al = alias_held(w.key_code, w.key_flags);
                        held_phys_tbl[held_total]  = w.physical_code;
                        held_key_tbl[held_total]   = w.key_code;
                        held_flags_tbl[held_total] = w.key_flags;
                        held_total++;
                        if (!al) queue_packet(w.key_code, 1'b1, w.key_flags);
                    end
                end
            end
            hkt_pkg::OP_CONSUME: begin
                drop_key(w.physical_code);
                suppressed[w.physical_code] = 1'b1;
            end
            hkt_pkg::OP_RELALL: begin
                while (held_total > 0) begin
                    q = held_phys_tbl[held_total - 1];
                    suppressed[q] = 1'b1;
                    drop_key(q);
                end
            end
            default: begin
                link_down = 1'b1;
            end
        endcase
        if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst = {burst, tail};
        end
    endtask

    function automatic hkt_pkg::t_in_word make_word(input logic [1:0] op, input int phys,
                                                    input int k, input int f, input bit down,
                                                    input bit rep, input bit allow);
        hkt_pkg::t_in_word w;
        w.opcode        = op;
        w.physical_code = phys[hkt_pkg::PHYS_W-1:0];
        w.key_code      = k[hkt_pkg::KEY_W-1:0];
        w.key_flags     = f[hkt_pkg::FLAGS_W-1:0];
        w.is_down       = down;
        w.is_repeat     = rep;
        w.allow_press   = allow;
        return w;
    endfunction

    function automatic hkt_pkg::t_out_word make_pkt(input int k, input bit down,
                                                    input logic [hkt_pkg::MASK_W-1:0] mask,
                                                    input int f);
        hkt_pkg::t_out_word pkt;
        pkt.out_key_code  = k[hkt_pkg::KEY_W-1:0];
        pkt.pressed       = down;
        pkt.modifier_mask = mask;
        pkt.out_flags     = f[hkt_pkg::FLAGS_W-1:0];
        pkt.last          = 1'b1;
        return pkt;
    endfunction

    task automatic add_row(input hkt_pkg::t_in_word w, input bit typed,
                           input hkt_pkg::t_out_word want);
        t_row r;
        r.w     = w;
        r.typed = typed;
        r.want  = want;
        rows = {rows, r};
    endtask

    // Offer one word, wait for the handshake, then record what it should cause.
    task automatic send_word(input hkt_pkg::t_in_word w, input bit typed,
                             input hkt_pkg::t_out_word want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        track_word(w);
        if (typed) begin
            burst.delete();
            burst = {burst, want};
        end
        foreach (burst[i]) pending_packets = {pending_packets, burst[i]};
    endtask

    // Fresh pool of keys: some modifiers, some aliases of earlier keys.
    task automatic new_session();
        int kind;
        int j;
        int code;
        for (int i = 0; i < POOL_SIZE; i++) begin
            kind = $urandom_range(9);
            code = $urandom_range(CODES - 1, 1);
            pool_phys[i]  = code[hkt_pkg::PHYS_W-1:0];
            pool_flags[i] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
            pool_key[i]   = 16'($urandom_range(65535));
            if (kind < 3) begin
                pool_key[i][15:8] = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
                case ($urandom_range(7))
                    0: pool_key[i][7:0] = hkt_pkg::KC_LSHIFT;
                    1: pool_key[i][7:0] = hkt_pkg::KC_RSHIFT;
                    2: pool_key[i][7:0] = hkt_pkg::KC_LCTRL;
                    3: pool_key[i][7:0] = hkt_pkg::KC_RCTRL;
                    4: pool_key[i][7:0] = hkt_pkg::KC_LALT;
                    5: pool_key[i][7:0] = hkt_pkg::KC_RALT;
                    6: pool_key[i][7:0] = hkt_pkg::KC_LMETA;
                    default: pool_key[i][7:0] = hkt_pkg::KC_RMETA;
                endcase
            end else if (kind < 5 && i > 0) begin
                j = $urandom_range(i - 1);
                pool_key[i]   = pool_key[j];
                pool_flags[i] = pool_flags[j];
            end
        end
    endtask

    // Mostly presses and releases of pool keys, with commands and noise mixed in.
    function automatic hkt_pkg::t_in_word session_word();
        hkt_pkg::t_in_word w;
        int                pick;
        int                slot;
        pick = $urandom_range(99);
        slot = $urandom_range(POOL_SIZE - 1);
        w = make_word(hkt_pkg::OP_KEY, pool_phys[slot], pool_key[slot], pool_flags[slot],
                      1'b1, ($urandom_range(9) == 0), ($urandom_range(9) != 0));
        if (pick < 45) begin
            w.is_down = 1'b1;
        end else if (pick < 80) begin
            w.is_down = 1'b0;
        end else if (pick < 86) begin
            w.opcode = hkt_pkg::OP_CONSUME;
        end else if (pick < 91) begin
            w.opcode = hkt_pkg::OP_RELALL;
        end else begin
            w = make_word(2'($urandom_range(2)), $urandom_range(CODES - 1),
                          $urandom_range(65535), $urandom_range(255),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
        return w;
    endfunction

    task automatic run_session(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        new_session();
        repeat (count) send_word(session_word(), 1'b0, '0);
    endtask

    // Fill the table past full while the receiver holds off, then release it all.
    task automatic squeeze_table();
        int base;
        send_idle_pct = 0;
        stall_pct     = 0;
        holds_asked++;
        base = $urandom_range(CODES - SLOTS - 2, 1);
        send_word(make_word(hkt_pkg::OP_RELALL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        for (int i = 0; i <= SLOTS; i++) begin
            send_word(make_word(hkt_pkg::OP_KEY, base + i, 0, 0, 1'b0, 1'b0, 1'b1),
                      1'b0, '0);
        end
        for (int i = 0; i <= SLOTS; i++) begin
            send_word(make_word(hkt_pkg::OP_KEY, base + i, $urandom_range(65535),
                                $urandom_range(255), 1'b1, 1'b0, 1'b1), 1'b0, '0);
        end
        send_word(make_word(hkt_pkg::OP_RELALL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    endtask

    task automatic report_field(input string what, input int expected, input int actual);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expected,
                 actual);
    endtask

    // Compare one delivered packet with the oldest one owed.
    task automatic check_packet(input hkt_pkg::t_out_word got);
        hkt_pkg::t_out_word want;
        if (pending_packets.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected packet, expected none, actual %h", $time, got);
            return;
        end
        want = pending_packets.pop_front();
        if (got.out_key_code !== want.out_key_code)
            report_field("key code", want.out_key_code, got.out_key_code);
        if (got.pressed !== want.pressed)
            report_field("pressed", want.pressed, got.pressed);
        if (got.modifier_mask !== want.modifier_mask)
            report_field("modifier mask", want.modifier_mask, got.modifier_mask);
        if (got.out_flags !== want.out_flags)
            report_field("flags", want.out_flags, got.out_flags);
        if (got.last !== want.last)
            report_field("last", want.last, got.last);
    endtask

    // Receiver: checks packets, stalls at random and takes long holds on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && i_out_ready === 1'b1 && o_out_valid === 1'b1)
                check_packet(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_asked != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Guard against a hung block.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int closing_from;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // Directed words, in order: plain press, shift press, repeat, unknown code,
        // duplicate press, suppression and its clearing, alias press and release.
        add_row(make_word(hkt_pkg::OP_KEY, 1, 16'h0041, 8'h00, 1, 0, 1), 1'b1,
                make_pkt(16'h0041, 1'b1, hkt_pkg::MOD_NONE, 8'h00));
        add_row(make_word(hkt_pkg::OP_KEY, 2, 16'h00A0, 8'h00, 1, 0, 1), 1'b1,
                make_pkt(16'h00A0, 1'b1, hkt_pkg::MOD_SHIFT, 8'h00));
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 1, 1, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 0, 16'h0042, 8'h00, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 1, 16'h0041, 8'h00, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 1, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 0, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 1, 16'h0041, 8'h00, 0, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 3, 16'h0041, 8'h00, 0, 0, 1), 1'b0, '0);
        // Extremes of code and flags, then every modifier class.
        add_row(make_word(hkt_pkg::OP_KEY, 511, 16'hFFFF, 8'hFF, 1, 0, 1), 1'b1,
                make_pkt(16'hFFFF, 1'b1, hkt_pkg::MOD_SHIFT, 8'hFF));
        add_row(make_word(hkt_pkg::OP_KEY, 4, 16'h01A3, 8'h80, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 5, 16'h005C, 8'h01, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 6, 16'h00A5, 8'h7F, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 7, 16'hFF41, 8'h00, 1, 0, 1), 1'b0, '0);
        // Consume local, then release all on a busy and on an empty table.
        add_row(make_word(hkt_pkg::OP_CONSUME, 4, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 4, 16'h01A3, 8'h80, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_RELALL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_RELALL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 2, 16'h00A0, 8'h00, 0, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_CONSUME, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 256, 16'h0000, 8'h00, 1, 0, 1), 1'b1,
                make_pkt(16'h0000, 1'b1, hkt_pkg::MOD_NONE, 8'h00));
        add_row(make_word(hkt_pkg::OP_KEY, 256, 16'h0000, 8'h00, 0, 0, 1), 1'b1,
                make_pkt(16'h0000, 1'b0, hkt_pkg::MOD_NONE, 8'h00));
        closing_from = rows.size();
        // Closing words: link failure, after which only consume and release all still change the table.
        add_row(make_word(hkt_pkg::OP_KEY, 8, 16'h0042, 8'h10, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 9, 16'h00A2, 8'h20, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_LINKFAIL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 10, 16'h0043, 8'h00, 1, 0, 1), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_CONSUME, 8, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_RELALL, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(hkt_pkg::OP_KEY, 9, 16'h00A2, 8'h20, 0, 0, 1), 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < closing_from; i++) send_word(rows[i].w, rows[i].typed, rows[i].want);

        run_session(80, 0, 0);
        run_session(60, 82, 0);
        run_session(60, 0, 82);
        squeeze_table();
        run_session(70, 36, 36);

        send_idle_pct = 0;
        stall_pct     = 0;
        for (int i = closing_from; i < rows.size(); i++)
            send_word(rows[i].w, rows[i].typed, rows[i].want);
        i_in_valid <= 1'b0;

        // Drain, then leave room for any stray packet to show up.
        while (pending_packets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
